[hw/rtl/sps_pkg.sv]
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, constants and coil decode for the stepper pulse sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int unsigned CountW        = 16;
  localparam int unsigned ChargeW       = 6;
  localparam int unsigned PhaseW        = 2;

  localparam logic [CountW-1:0]  TicksPerSecond   = 16'd1000;
  localparam logic [CountW-1:0]  WakeTicks        = 16'd100;
  localparam logic [ChargeW-1:0] MaxChargeSeconds = 6'd60;
  localparam logic [PhaseW-1:0]  PhaseStart       = 2'd2;

  localparam logic OpTick  = 1'b0;
  localparam logic OpStart = 1'b1;

  // Sequencer stage, one-hot
  typedef enum logic [3:0] {
    STAGE_IDLE   = 4'b0001,
    STAGE_CHARGE = 4'b0010,
    STAGE_WAKE   = 4'b0100,
    STAGE_STEP   = 4'b1000
  } stage_e;

  // One input item
  typedef struct packed {
    logic               opcode;
    logic               reverse;
    logic [CountW-1:0]  pulse_count;
    logic [CountW-1:0]  pulse_ms;
    logic [ChargeW-1:0] charge_seconds;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic              power_on;
    logic              awake;
    logic              phase_a;
    logic              phase_b;
    logic              enable_a;
    logic              enable_b;
    logic              busy_res;
    logic [CountW-1:0] step_index;
    logic [PhaseW-1:0] phase_index;
    logic              finished;
    logic              rejected;
  } result_t;

  // Coil latches and enables for a new phase; bit 0 is coil A, bit 1 coil B
  typedef struct packed {
    logic [1:0] latches;
    logic [1:0] enables;
  } coil_t;

  function automatic coil_t coil_decode(logic two_coil, logic [PhaseW-1:0] phase,
                                        logic [1:0] lat_cur);
    coil_t c;
    c.latches = lat_cur;
    c.enables = 2'b00;
    if (two_coil) begin
      c.enables = 2'b11;
      case (phase)
        2'd0:    c.latches = 2'b11;
        2'd1:    c.latches = 2'b10;
        2'd2:    c.latches = 2'b00;
        default: c.latches = 2'b01;
      endcase
    end else begin
      case (phase)
        2'd0: begin
          c.latches[0] = 1'b1;
          c.enables    = 2'b01;
        end
        2'd1: begin
          c.latches[1] = 1'b1;
          c.enables    = 2'b10;
        end
        2'd2: begin
          c.latches[0] = 1'b0;
          c.enables    = 2'b01;
        end
        default: begin
          c.latches[1] = 1'b0;
          c.enables    = 2'b10;
        end
      endcase
    end
    return c;
  endfunction

endpackage

[hw/rtl/stepper_pulse_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// stepper_pulse_sequencer_unit
// Top level: input register, sequencer core, result register.
// ----------------------------------------------------------------------------
// Each input item is a 1 ms tick or a start command and produces exactly one
// result showing the driver pins and progress after that item. An accepted
// item is held in the input register until the result register is free or
// drains; it is then applied to the sequencer state and captured in the
// result register at the same edge, and its result is offered from there.
// One item is taken every cycle as long as the result side keeps up; a
// stalled result holds the input register, which stalls the input in the same
// cycle. The single state update in the core is what bounds this. The
// drive_mode register is written through the cfg channel, which is always
// ready, and is sampled when each step begins.
module stepper_pulse_sequencer_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_drive_mode_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic                           reverse_i,
  input  logic [sps_pkg::CountW-1:0]     pulse_count_i,
  input  logic [sps_pkg::CountW-1:0]     pulse_ms_i,
  input  logic [sps_pkg::ChargeW-1:0]    charge_seconds_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           power_on_o,
  output logic                           awake_o,
  output logic                           phase_a_o,
  output logic                           phase_b_o,
  output logic                           enable_a_o,
  output logic                           enable_b_o,
  output logic                           busy_res_o,
  output logic [sps_pkg::CountW-1:0]     step_index_o,
  output logic [sps_pkg::PhaseW-1:0]     phase_index_o,
  output logic                           finished_o,
  output logic                           rejected_o
);
  import sps_pkg::*;

  logic    in_vld_q, out_vld_q;
  cmd_t    cmd_q;
  result_t res, res_q;
  logic    adv, in_take;

  // Item moves to the result register when that register is free or drains
  assign adv         = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && !adv;
  assign in_take     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_take || (in_vld_q && !adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q.opcode         <= opcode_i;
      cmd_q.reverse        <= reverse_i;
      cmd_q.pulse_count    <= pulse_count_i;
      cmd_q.pulse_ms       <= pulse_ms_i;
      cmd_q.charge_seconds <= charge_seconds_i;
    end
  end

  sps_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_drive_mode_i (cfg_drive_mode_i),
    .item_valid_i     (adv),
    .item_i           (cmd_q),
    .result_o         (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign power_on_o    = res_q.power_on;
  assign awake_o       = res_q.awake;
  assign phase_a_o     = res_q.phase_a;
  assign phase_b_o     = res_q.phase_b;
  assign enable_a_o    = res_q.enable_a;
  assign enable_b_o    = res_q.enable_b;
  assign busy_res_o    = res_q.busy_res;
  assign step_index_o  = res_q.step_index;
  assign phase_index_o = res_q.phase_index;
  assign finished_o    = res_q.finished;
  assign rejected_o    = res_q.rejected;

endmodule

[hw/rtl/sps_core.sv]
// ----------------------------------------------------------------------------
// sps_core
// Sequencer state and next-state logic: applies one tick or start per cycle
// while item_valid_i is high and produces the matching result.
// ----------------------------------------------------------------------------
module sps_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_drive_mode_i,
  input  logic            item_valid_i,
  input  sps_pkg::cmd_t   item_i,
  output sps_pkg::result_t result_o
);
  import sps_pkg::*;

  stage_e             stage_q, stage_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [CountW-1:0]  steps_q, steps_d;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [1:0]         lat_q, lat_d;
  logic [1:0]         en_q, en_d;
  logic               hrev_q, hrev_d;
  logic [CountW-1:0]  hcount_q, hcount_d;
  logic [CountW-1:0]  hms_q, hms_d;
  logic               mode_q;
  logic               finished, rejected;
  logic [ChargeW-1:0] secs;
  logic [PhaseW-1:0]  phase_nxt;
  coil_t              coil;

  // Clamped charge time and the phase/coils a new step would take
  assign secs      = (item_i.charge_seconds > MaxChargeSeconds) ?
                     MaxChargeSeconds : item_i.charge_seconds;
  assign phase_nxt = hrev_q ? phase_q - 2'd1 : phase_q + 2'd1;
  assign coil      = coil_decode(mode_q, phase_nxt, lat_q);

  // Next-state logic
  always_comb begin
    stage_d  = stage_q;
    cnt_d    = cnt_q;
    steps_d  = steps_q;
    phase_d  = phase_q;
    lat_d    = lat_q;
    en_d     = en_q;
    hrev_d   = hrev_q;
    hcount_d = hcount_q;
    hms_d    = hms_q;
    finished = 1'b0;
    rejected = 1'b0;
    if (item_valid_i) begin
      if (item_i.opcode == OpStart) begin
        if (stage_q != STAGE_IDLE) begin
          rejected = 1'b1;
        end else begin
          hrev_d   = item_i.reverse;
          hcount_d = item_i.pulse_count;
          hms_d    = item_i.pulse_ms;
          steps_d  = '0;
          phase_d  = PhaseStart;
          en_d     = 2'b00;
          if (secs == '0) begin
            stage_d = STAGE_WAKE;
            cnt_d   = WakeTicks;
          end else begin
            stage_d = STAGE_CHARGE;
            cnt_d   = CountW'(CountW'(secs) * TicksPerSecond);
          end
        end
      end else if (stage_q != STAGE_IDLE) begin
        if (cnt_q > CountW'(1)) begin
          cnt_d = cnt_q - CountW'(1);
        end else begin
          cnt_d = '0;
          if (stage_q == STAGE_CHARGE) begin
            stage_d = STAGE_WAKE;
            cnt_d   = WakeTicks;
          end else begin
            if (stage_q == STAGE_STEP) begin
              en_d    = 2'b00;
              steps_d = steps_q + CountW'(1);
            end
            // next step or finish
            if (steps_d < hcount_q) begin
              phase_d = phase_nxt;
              lat_d   = coil.latches;
              en_d    = coil.enables;
              cnt_d   = (hms_q == '0) ? CountW'(1) : hms_q;
              stage_d = STAGE_STEP;
            end else begin
              en_d     = 2'b00;
              cnt_d    = '0;
              stage_d  = STAGE_IDLE;
              finished = 1'b1;
            end
          end
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= STAGE_IDLE;
      cnt_q    <= '0;
      steps_q  <= '0;
      phase_q  <= PhaseStart;
      lat_q    <= '0;
      en_q     <= '0;
      hrev_q   <= 1'b0;
      hcount_q <= '0;
      hms_q    <= '0;
      mode_q   <= 1'b0;
    end else begin
      stage_q  <= stage_d;
      cnt_q    <= cnt_d;
      steps_q  <= steps_d;
      phase_q  <= phase_d;
      lat_q    <= lat_d;
      en_q     <= en_d;
      hrev_q   <= hrev_d;
      hcount_q <= hcount_d;
      hms_q    <= hms_d;
      if (cfg_we_i) begin
        mode_q <= cfg_drive_mode_i;
      end
    end
  end

  // Result as seen after this item
  always_comb begin
    result_o.power_on    = (stage_d != STAGE_IDLE);
    result_o.awake       = (stage_d == STAGE_WAKE) || (stage_d == STAGE_STEP);
    result_o.phase_a     = lat_d[0];
    result_o.phase_b     = lat_d[1];
    result_o.enable_a    = en_d[0];
    result_o.enable_b    = en_d[1];
    result_o.busy_res    = (stage_d != STAGE_IDLE);
    result_o.step_index  = steps_d;
    result_o.phase_index = phase_d;
    result_o.finished    = finished;
    result_o.rejected    = rejected;
  end

  // Checks
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && finished |=> stage_q == STAGE_IDLE)
    else $error("finish did not return to idle");
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rejected |-> stage_q != STAGE_IDLE)
    else $error("start rejected while idle");
  a_step_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q == STAGE_STEP |-> en_q != 2'b00)
    else $error("step stage with no coil enabled");
  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q != STAGE_IDLE |-> steps_q <= hcount_q)
    else $error("step count ran past the requested count");
  a_wake_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_q == STAGE_WAKE |-> cnt_q != '0 && cnt_q <= WakeTicks)
    else $error("wake counter out of range");

endmodule

[verif/tb_stepper_pulse_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// tb_stepper_pulse_sequencer_unit
// Self-checking bench for the stepper pulse sequencer. A directed plan covers
// the reset state, busy rejection with every field at its top, wave drive in
// both directions, two-coil reverse, zero counts and zero pulse lengths.
// Random start/tick traffic follows. Results are checked against the in-bench
// model or a typed row's value; both handshakes are throttled at random.
// ----------------------------------------------------------------------------
module tb_stepper_pulse_sequencer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned RandomItems = 600;

  typedef enum logic {
    ROW_ITEM = 1'b0,
    ROW_MODE = 1'b1
  } row_kind_e;

  // One plan row: a mode write, or an item sent reps times
  typedef struct packed {
    row_kind_e   kind;
    logic        mode;
    cmd_t        cmd;
    int unsigned reps;
    logic        quiet;
    logic        typed;
    result_t     want;
  } row_t;

  localparam row_t PLAN [13] = '{
    // after reset: idle, phase parked at two
    '{ROW_ITEM, 1'b0, '{OpTick, 1'b0, 16'd0, 16'd0, 6'd0}, 1, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 2'd2, 1'b0, 1'b0}},
    '{ROW_ITEM, 1'b0, '{OpTick, 1'b0, 16'd0, 16'd0, 6'd0}, 3, 1'b0, 1'b0, '0},
    '{ROW_MODE, 1'b0, '0, 0, 1'b0, 1'b0, '0},
    // wave drive forward, no charge wait
    '{ROW_ITEM, 1'b0, '{OpStart, 1'b0, 16'd6, 16'd2, 6'd0}, 1, 1'b0, 1'b0, '0},
    // start while busy, all fields at their top
    '{ROW_ITEM, 1'b0, '{OpStart, 1'b1, 16'hFFFF, 16'hFFFF, 6'h3F}, 1, 1'b0, 1'b1,
      '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0, 2'd2, 1'b0, 1'b1}},
    '{ROW_ITEM, 1'b0, '{OpTick, 1'b0, 16'd0, 16'd0, 6'd0}, 114, 1'b0, 1'b0, '0},
    '{ROW_MODE, 1'b1, '0, 0, 1'b0, 1'b0, '0},
    // two-coil reverse with one-tick pulses
    '{ROW_ITEM, 1'b0, '{OpStart, 1'b1, 16'd5, 16'd0, 6'd0}, 1, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 1'b0, '{OpTick, 1'b0, 16'd0, 16'd0, 6'd0}, 107, 1'b0, 1'b0, '0},
    // zero pulse count ends right after the awake wait
    '{ROW_ITEM, 1'b0, '{OpStart, 1'b0, 16'd0, 16'd7, 6'd0}, 1, 1'b0, 1'b0, '0},
    '{ROW_ITEM, 1'b0, '{OpTick, 1'b0, 16'd0, 16'd0, 6'd0}, 102, 1'b0, 1'b0, '0},
    '{ROW_MODE, 1'b0, '0, 0, 1'b0, 1'b0, '0},
    // wave drive reverse, wraps the phase twice
    '{ROW_ITEM, 1'b0, '{OpStart, 1'b1, 16'd9, 16'd1, 6'd0}, 1, 1'b0, 1'b0, '0}
  };

  localparam int unsigned TailTicks = 111;

  // Two-coil latch pattern per phase, bit 0 coil A
  localparam logic [1:0] TWO_COIL_LATCHES [4] = '{2'b11, 2'b10, 2'b00, 2'b01};

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_valid_i      = 1'b0;
  logic                cfg_ready_o;
  logic                cfg_drive_mode_i = 1'b0;
  logic                in_valid_i       = 1'b0;
  logic                in_stall_o;
  logic                opcode_i         = OpTick;
  logic                reverse_i        = 1'b0;
  logic [CountW-1:0]   pulse_count_i    = '0;
  logic [CountW-1:0]   pulse_ms_i       = '0;
  logic [ChargeW-1:0]  charge_seconds_i = '0;
  logic                out_valid_o;
  logic                out_stall_i      = 1'b0;
  logic                power_on_o;
  logic                awake_o;
  logic                phase_a_o;
  logic                phase_b_o;
  logic                enable_a_o;
  logic                enable_b_o;
  logic                busy_res_o;
  logic [CountW-1:0]   step_index_o;
  logic [PhaseW-1:0]   phase_index_o;
  logic                finished_o;
  logic                rejected_o;

  stepper_pulse_sequencer_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_drive_mode_i (cfg_drive_mode_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .reverse_i        (reverse_i),
    .pulse_count_i    (pulse_count_i),
    .pulse_ms_i       (pulse_ms_i),
    .charge_seconds_i (charge_seconds_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .power_on_o       (power_on_o),
    .awake_o          (awake_o),
    .phase_a_o        (phase_a_o),
    .phase_b_o        (phase_b_o),
    .enable_a_o       (enable_a_o),
    .enable_b_o       (enable_b_o),
    .busy_res_o       (busy_res_o),
    .step_index_o     (step_index_o),
    .phase_index_o    (phase_index_o),
    .finished_o       (finished_o),
    .rejected_o       (rejected_o)
  );

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  // Sequencer model state
  stage_e            stage_q   = STAGE_IDLE;
  int unsigned       wait_q    = 0;
  logic [CountW-1:0] steps_q   = '0;
  logic [PhaseW-1:0] phase_q   = PhaseStart;
  logic [1:0]        latch_q   = 2'b00;
  logic [1:0]        enable_q  = 2'b00;
  logic              rev_q     = 1'b0;
  logic [CountW-1:0] count_q   = '0;
  logic [CountW-1:0] ms_q      = '0;
  logic              mode_q    = 1'b0;

  result_t     expected_pins [$];
  int unsigned mismatch_count = 0;
  bit          quiet = 1'b0;

  function automatic void enter_wake();
    stage_q = STAGE_WAKE;
    wait_q  = 32'(WakeTicks);
  endfunction

  // Begin the next step, or return to idle when all are done (returns 1)
  function automatic logic step_or_finish();
    if (steps_q < count_q) begin
      phase_q = rev_q ? phase_q - 2'd1 : phase_q + 2'd1;
      if (mode_q) begin
        latch_q  = TWO_COIL_LATCHES[phase_q];
        enable_q = 2'b11;
      end else begin
        case (phase_q)
          2'd0: begin
            latch_q[0] = 1'b1;
            enable_q   = 2'b01;
          end
          2'd1: begin
            latch_q[1] = 1'b1;
            enable_q   = 2'b10;
          end
          2'd2: begin
            latch_q[0] = 1'b0;
            enable_q   = 2'b01;
          end
          default: begin
            latch_q[1] = 1'b0;
            enable_q   = 2'b10;
          end
        endcase
      end
      wait_q  = (ms_q == '0) ? 1 : int'(ms_q);
      stage_q = STAGE_STEP;
      return 1'b0;
    end
    enable_q = 2'b00;
    wait_q   = 0;
    stage_q  = STAGE_IDLE;
    return 1'b1;
  endfunction

  // Apply one accepted item to the model and return the pins it leaves
  function automatic result_t sequencer_advance(input cmd_t c);
    result_t           r;
    logic              done;
    logic              refused;
    logic [ChargeW-1:0] secs;
    done    = 1'b0;
    refused = 1'b0;
    if (c.opcode == OpStart) begin
      if (stage_q != STAGE_IDLE) begin
        refused = 1'b1;
      end else begin
        secs     = (c.charge_seconds > MaxChargeSeconds) ? MaxChargeSeconds
                                                          : c.charge_seconds;
        rev_q    = c.reverse;
        count_q  = c.pulse_count;
        ms_q     = c.pulse_ms;
        steps_q  = '0;
        phase_q  = PhaseStart;
        enable_q = 2'b00;
        stage_q  = STAGE_CHARGE;
        wait_q   = int'(secs) * int'(TicksPerSecond);
        if (wait_q == 0) enter_wake();
      end
    end else if (stage_q != STAGE_IDLE) begin
      if (wait_q > 1) begin
        wait_q--;
      end else begin
        wait_q = 0;
        case (stage_q)
          STAGE_CHARGE: enter_wake();
          STAGE_WAKE:   done = step_or_finish();
          default: begin
            enable_q = 2'b00;
            steps_q  = steps_q + 1'b1;
            done     = step_or_finish();
          end
        endcase
      end
    end
    r.power_on    = (stage_q != STAGE_IDLE);
    r.awake       = (stage_q == STAGE_WAKE) || (stage_q == STAGE_STEP);
    r.phase_a     = latch_q[0];
    r.phase_b     = latch_q[1];
    r.enable_a    = enable_q[0];
    r.enable_b    = enable_q[1];
    r.busy_res    = (stage_q != STAGE_IDLE);
    r.step_index  = steps_q;
    r.phase_index = phase_q;
    r.finished    = done;
    r.rejected    = refused;
    return r;
  endfunction

  // Input side: gap, then hold the item until the transfer
  task automatic send_item(input cmd_t c, input logic typed, input result_t want);
    int unsigned gap;
    result_t     r;
    gap = quiet ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    opcode_i         <= c.opcode;
    reverse_i        <= c.reverse;
    pulse_count_i    <= c.pulse_count;
    pulse_ms_i       <= c.pulse_ms;
    charge_seconds_i <= c.charge_seconds;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = sequencer_advance(c);
    expected_pins.push_back(typed ? want : r);
  endtask

  // Stop sending and wait until every expected result is in
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pins.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i      <= 1'b1;
    cfg_drive_mode_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mode_q = m;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result side: per-result stall, check on each transfer
  initial begin : result_side
    int unsigned hold;
    result_t     w;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_pins.size() == 0) begin
          $error("result transfer with nothing expected");
          mismatch_count++;
        end else begin
          w = expected_pins.pop_front();
          compare_field("power_on",    32'(w.power_on),    32'(power_on_o));
          compare_field("awake",       32'(w.awake),       32'(awake_o));
          compare_field("phase_a",     32'(w.phase_a),     32'(phase_a_o));
          compare_field("phase_b",     32'(w.phase_b),     32'(phase_b_o));
          compare_field("enable_a",    32'(w.enable_a),    32'(enable_a_o));
          compare_field("enable_b",    32'(w.enable_b),    32'(enable_b_o));
          compare_field("busy_res",    32'(w.busy_res),    32'(busy_res_o));
          compare_field("step_index",  32'(w.step_index),  32'(step_index_o));
          compare_field("phase_index", 32'(w.phase_index), 32'(phase_index_o));
          compare_field("finished",    32'(w.finished),    32'(finished_o));
          compare_field("rejected",    32'(w.rejected),    32'(rejected_o));
        end
        hold = quiet ? 0 : $urandom_range(0, 15);
      end
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) break;
    end
    $error("no transfer for %0d cycles", IdleLimit);
    $display("tb_stepper_pulse_sequencer_unit: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned counted;
    int unsigned n;
    bit          paused;
    cmd_t        c;
    counted = 0;
    paused  = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed plan
    foreach (PLAN[i]) begin
      quiet = PLAN[i].quiet;
      if (PLAN[i].kind == ROW_MODE) begin
        write_mode(PLAN[i].mode);
      end else begin
        repeat (PLAN[i].reps) send_item(PLAN[i].cmd, PLAN[i].typed, PLAN[i].want);
      end
    end
    quiet = 1'b0;
    // run the last directed sequence out
    repeat (TailTicks) send_item('0, 1'b0, '0);

    // random sequences, with rejected starts as noise while busy
    while (counted < RandomItems) begin
      c = '0;
      if (stage_q == STAGE_IDLE) begin
        if ($urandom_range(0, 3) == 0) begin
          write_mode(1'($urandom_range(0, 1)));
        end else if (!paused && counted > RandomItems / 2) begin
          drain_results();
          paused = 1'b1;
        end
        n = $urandom_range(0, 2);
        repeat (n) send_item(c, 1'b0, '0);
        c.opcode      = OpStart;
        c.reverse     = 1'($urandom_range(0, 1));
        c.pulse_count = CountW'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 12)
                                                            : $urandom_range(0, 5));
        c.pulse_ms    = CountW'($urandom_range(0, 4));
        c.charge_seconds = '0;
        quiet = ($urandom_range(0, 4) == 0);
      end else if ($urandom_range(0, 15) == 0) begin
        c.opcode         = OpStart;
        c.reverse        = 1'($urandom_range(0, 1));
        c.pulse_count    = CountW'($urandom_range(0, 16'hFFFF));
        c.pulse_ms       = CountW'($urandom_range(0, 16'hFFFF));
        c.charge_seconds = ChargeW'($urandom_range(0, 63));
      end
      if ((c.opcode == OpStart) == (stage_q == STAGE_IDLE)) counted++;
      send_item(c, 1'b0, '0);
    end
    quiet = 1'b0;

    drain_results();
    repeat (8) @(posedge clk_i);
    if (expected_pins.size() != 0) begin
      $error("%0d expected results never arrived", expected_pins.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb_stepper_pulse_sequencer_unit: PASS");
    end else begin
      $display("tb_stepper_pulse_sequencer_unit: FAIL");
    end
    $finish;
  end

endmodule
